FILE: hw/rtl/i2cms_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2cms_pkg
// Shared types and codes for the I2C master register sequencer.
// ----------------------------------------------------------------------------
package i2cms_pkg;

    localparam logic OP_REQUEST = 1'b0;
    localparam logic OP_STATUS  = 1'b1;

    localparam logic [7:0] ST_START      = 8'h08;
    localparam logic [7:0] ST_RESTART    = 8'h10;
    localparam logic [7:0] ST_ADDR_W_ACK = 8'h18;
    localparam logic [7:0] ST_DATA_W_ACK = 8'h28;
    localparam logic [7:0] ST_ADDR_R_ACK = 8'h40;
    localparam logic [7:0] ST_DATA_R_ACK = 8'h50;
    localparam logic [7:0] ST_DATA_R_NAK = 8'h58;

    localparam logic [1:0] START_NONE  = 2'd0;
    localparam logic [1:0] START_SET   = 2'd1;
    localparam logic [1:0] START_CLEAR = 2'd2;

    localparam logic [1:0] ACK_NONE  = 2'd0;
    localparam logic [1:0] ACK_SET   = 2'd1;
    localparam logic [1:0] ACK_CLEAR = 2'd2;

    localparam logic [1:0] COMP_BUSY  = 2'd0;
    localparam logic [1:0] COMP_READ  = 2'd1;
    localparam logic [1:0] COMP_WRITE = 2'd2;

    localparam int CNT_W = 9;

    typedef struct packed {
        logic       operation;
        logic [7:0] device_address;
        logic [7:0] register_address;
        logic [7:0] write_value;
        logic       read_request;
        logic [7:0] byte_count;
        logic [7:0] status_code;
        logic [7:0] received_byte;
    } req_t;

    typedef struct packed {
        logic       load_data;
        logic [7:0] tx_byte;
        logic [1:0] start_action;
        logic       stop_request;
        logic [1:0] ack_action;
        logic       clear_interrupt;
        logic [1:0] completion;
        logic [7:0] read_data;
    } rsp_t;

endpackage

FILE: hw/rtl/i2cms_input_stage.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2cms_input_stage
// Input register with valid/ready flow control.
// ----------------------------------------------------------------------------
module i2cms_input_stage (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            req_valid,
    output logic            req_ready,
    input  i2cms_pkg::req_t req,
    input  logic            down_ready,
    output logic            stage_valid,
    output i2cms_pkg::req_t stage_item
);

    logic            valid_reg;
    i2cms_pkg::req_t item_reg;

    assign req_ready   = !valid_reg || down_ready;
    assign stage_valid = valid_reg;
    assign stage_item  = item_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (req_ready)
        begin
            valid_reg <= req_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_valid && req_ready)
        begin
            item_reg <= req;
        end
    end

endmodule

FILE: hw/rtl/i2cms_sequencer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2cms_sequencer
// Transaction state and status-code decode into controller commands.
// ----------------------------------------------------------------------------
module i2cms_sequencer (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            fire,
    input  i2cms_pkg::req_t item,
    output i2cms_pkg::rsp_t result
);

    logic [7:0]                        target_address_reg;
    logic [7:0]                        target_register_reg;
    logic [7:0]                        data_byte_reg;
    logic signed [i2cms_pkg::CNT_W-1:0] tx_remaining_reg;
    logic signed [i2cms_pkg::CNT_W-1:0] rx_remaining_reg;
    logic                              read_mode_reg;

    logic [7:0]                        target_address_next;
    logic [7:0]                        target_register_next;
    logic [7:0]                        data_byte_next;
    logic signed [i2cms_pkg::CNT_W-1:0] tx_remaining_next;
    logic signed [i2cms_pkg::CNT_W-1:0] rx_remaining_next;
    logic                              read_mode_next;

    logic tx_has_one;
    logic rx_has_two;

    assign tx_has_one = tx_remaining_reg >= $signed(9'sd1);
    assign rx_has_two = rx_remaining_reg >= $signed(9'sd2);

    always_comb
    begin
        target_address_next  = target_address_reg;
        target_register_next = target_register_reg;
        data_byte_next       = data_byte_reg;
        tx_remaining_next    = tx_remaining_reg;
        rx_remaining_next    = rx_remaining_reg;
        read_mode_next       = read_mode_reg;

        result.load_data       = 1'b0;
        result.tx_byte         = 8'h00;
        result.start_action    = i2cms_pkg::START_NONE;
        result.stop_request    = 1'b0;
        result.ack_action      = i2cms_pkg::ACK_NONE;
        result.clear_interrupt = 1'b0;
        result.completion      = i2cms_pkg::COMP_BUSY;

        if (item.operation == i2cms_pkg::OP_REQUEST)
        begin
            target_address_next  = item.device_address;
            target_register_next = item.register_address;
            if (item.read_request)
            begin
                rx_remaining_next = $signed({1'b0, item.byte_count});
                read_mode_next    = 1'b1;
            end
            else
            begin
                data_byte_next    = item.write_value;
                tx_remaining_next = $signed({1'b0, item.byte_count});
                read_mode_next    = 1'b0;
            end
            result.start_action = i2cms_pkg::START_SET;
        end
        else
        begin
            result.clear_interrupt = 1'b1;
            unique case (item.status_code)
                i2cms_pkg::ST_START:
                begin
                    result.load_data = 1'b1;
                    result.tx_byte   = {target_address_reg[7:1], 1'b0};
                end
                i2cms_pkg::ST_RESTART:
                begin
                    result.load_data = 1'b1;
                    result.tx_byte   = {target_address_reg[7:1], 1'b1};
                end
                i2cms_pkg::ST_ADDR_W_ACK:
                begin
                    result.start_action = i2cms_pkg::START_CLEAR;
                    result.load_data    = 1'b1;
                    result.tx_byte      = target_register_reg;
                end
                i2cms_pkg::ST_DATA_W_ACK:
                begin
                    if (!read_mode_reg)
                    begin
                        if (tx_has_one)
                        begin
                            result.load_data = 1'b1;
                            result.tx_byte   = data_byte_reg;
                        end
                        else
                        begin
                            result.stop_request = 1'b1;
                            result.completion   = i2cms_pkg::COMP_WRITE;
                        end
                        tx_remaining_next = tx_remaining_reg - 9'sd1;
                    end
                    else
                    begin
                        result.start_action = i2cms_pkg::START_SET;
                    end
                end
                i2cms_pkg::ST_ADDR_R_ACK:
                begin
                    result.start_action = i2cms_pkg::START_CLEAR;
                    result.ack_action   = rx_has_two ? i2cms_pkg::ACK_SET
                                                     : i2cms_pkg::ACK_CLEAR;
                end
                i2cms_pkg::ST_DATA_R_ACK:
                begin
                    data_byte_next    = item.received_byte;
                    result.ack_action = rx_has_two ? i2cms_pkg::ACK_SET
                                                   : i2cms_pkg::ACK_CLEAR;
                    rx_remaining_next = rx_remaining_reg - 9'sd1;
                end
                i2cms_pkg::ST_DATA_R_NAK:
                begin
                    data_byte_next      = item.received_byte;
                    result.stop_request = 1'b1;
                    result.completion   = i2cms_pkg::COMP_READ;
                end
                default:
                begin
                    result.stop_request = 1'b1;
                    result.completion   = i2cms_pkg::COMP_WRITE;
                end
            endcase
        end

        result.read_data = data_byte_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            target_address_reg  <= 8'h00;
            target_register_reg <= 8'h00;
            data_byte_reg       <= 8'h00;
            tx_remaining_reg    <= '0;
            rx_remaining_reg    <= '0;
            read_mode_reg       <= 1'b0;
        end
        else if (fire)
        begin
            target_address_reg  <= target_address_next;
            target_register_reg <= target_register_next;
            data_byte_reg       <= data_byte_next;
            tx_remaining_reg    <= tx_remaining_next;
            rx_remaining_reg    <= rx_remaining_next;
            read_mode_reg       <= read_mode_next;
        end
    end

endmodule

FILE: hw/rtl/i2cms_result_stage.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2cms_result_stage
// Result register with valid/ready flow control.
// ----------------------------------------------------------------------------
module i2cms_result_stage (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            up_valid,
    output logic            up_ready,
    input  i2cms_pkg::rsp_t up_result,
    output logic            rsp_valid,
    input  logic            rsp_ready,
    output i2cms_pkg::rsp_t rsp
);

    logic            valid_reg;
    i2cms_pkg::rsp_t result_reg;

    assign up_ready  = !valid_reg || rsp_ready;
    assign rsp_valid = valid_reg;
    assign rsp       = result_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (up_ready)
        begin
            valid_reg <= up_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (up_valid && up_ready)
        begin
            result_reg <= up_result;
        end
    end

endmodule

FILE: hw/rtl/i2c_master_register_sequencer.sv
`timescale 1ns / 1ps
// Path: an accepted transaction is held in the input register, then passes
// through the sequencer into the result register, where it is shown on rsp.
// Throughput: one transaction per cycle while rsp_ready stays high; the input register and the result
// register each advance whenever the stage after them can take data.
// Reset: rst_n clears all sequencer state and both valid flags at once.
// ----------------------------------------------------------------------------
// i2c_master_register_sequencer
// Sequences a single-register I2C master transfer over a status-code
// controller: requests latch the transfer, status events give commands.
// ----------------------------------------------------------------------------
module i2c_master_register_sequencer (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            req_valid,
    output logic            req_ready,
    input  i2cms_pkg::req_t req,
    output logic            rsp_valid,
    input  logic            rsp_ready,
    output i2cms_pkg::rsp_t rsp
);

    logic            stage_valid;
    i2cms_pkg::req_t stage_item;
    logic            res_ready;
    i2cms_pkg::rsp_t seq_result;

    i2cms_input_stage u_input (
        .clk         (clk),
        .rst_n       (rst_n),
        .req_valid   (req_valid),
        .req_ready   (req_ready),
        .req         (req),
        .down_ready  (res_ready),
        .stage_valid (stage_valid),
        .stage_item  (stage_item)
    );

    i2cms_sequencer u_seq (
        .clk    (clk),
        .rst_n  (rst_n),
        .fire   (stage_valid && res_ready),
        .item   (stage_item),
        .result (seq_result)
    );

    i2cms_result_stage u_result (
        .clk       (clk),
        .rst_n     (rst_n),
        .up_valid  (stage_valid),
        .up_ready  (res_ready),
        .up_result (seq_result),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

endmodule

FILE: tb/sv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the I2C master register sequencer. Drives write and
// read transfers, noise events and a long counter wraparound run through the
// request channel while both channels idle at random, and compares every
// command set on the response channel against an in-bench model of the
// sequencer.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int CLK_PERIOD = 20;
    localparam int LIMIT      = 200000;

    logic            clk;
    logic            rst_n;
    logic            req_valid;
    logic            req_ready;
    i2cms_pkg::req_t req;
    logic            rsp_valid;
    logic            rsp_ready;
    i2cms_pkg::rsp_t rsp;

    // model state
    logic [7:0] m_dev;
    logic [7:0] m_reg;
    logic [7:0] m_data;
    logic [8:0] m_tx;
    logic [8:0] m_rx;
    logic       m_rd;

    i2cms_pkg::rsp_t pending_cmds[$];
    int   errors;
    int   sent;
    int   checked;
    int   cycles;
    bit   calm;
    int   stall_len;

    i2c_master_register_sequencer DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

    initial
    begin
        clk = 1'b0;
        forever #(CLK_PERIOD / 2) clk = ~clk;
    end

    function automatic i2cms_pkg::rsp_t next_commands(input i2cms_pkg::req_t t);
        i2cms_pkg::rsp_t r;
        r = '0;
        if (t.operation == i2cms_pkg::OP_REQUEST)
        begin
            m_dev = t.device_address;
            m_reg = t.register_address;
            if (t.read_request)
            begin
                m_rx = {1'b0, t.byte_count};
                m_rd = 1'b1;
            end
            else
            begin
                m_data = t.write_value;
                m_tx   = {1'b0, t.byte_count};
                m_rd   = 1'b0;
            end
            r.start_action = i2cms_pkg::START_SET;
        end
        else
        begin
            r.clear_interrupt = 1'b1;
            case (t.status_code)
                i2cms_pkg::ST_START:
                begin
                    r.load_data = 1'b1;
                    r.tx_byte   = m_dev & 8'hFE;
                end
                i2cms_pkg::ST_RESTART:
                begin
                    r.load_data = 1'b1;
                    r.tx_byte   = m_dev | 8'h01;
                end
                i2cms_pkg::ST_ADDR_W_ACK:
                begin
                    r.start_action = i2cms_pkg::START_CLEAR;
                    r.load_data    = 1'b1;
                    r.tx_byte      = m_reg;
                end
                i2cms_pkg::ST_DATA_W_ACK:
                begin
                    if (!m_rd)
                    begin
                        if ($signed(m_tx) >= 9'sd1)
                        begin
                            r.load_data = 1'b1;
                            r.tx_byte   = m_data;
                        end
                        else
                        begin
                            r.stop_request = 1'b1;
                            r.completion   = i2cms_pkg::COMP_WRITE;
                        end
                        m_tx = m_tx - 9'd1;
                    end
                    else
                        r.start_action = i2cms_pkg::START_SET;
                end
                i2cms_pkg::ST_ADDR_R_ACK:
                begin
                    r.start_action = i2cms_pkg::START_CLEAR;
                    r.ack_action   = ($signed(m_rx) >= 9'sd2) ? i2cms_pkg::ACK_SET
                                                              : i2cms_pkg::ACK_CLEAR;
                end
                i2cms_pkg::ST_DATA_R_ACK:
                begin
                    m_data       = t.received_byte;
                    r.ack_action = ($signed(m_rx) >= 9'sd2) ? i2cms_pkg::ACK_SET
                                                            : i2cms_pkg::ACK_CLEAR;
                    m_rx         = m_rx - 9'd1;
                end
                i2cms_pkg::ST_DATA_R_NAK:
                begin
                    m_data         = t.received_byte;
                    r.stop_request = 1'b1;
                    r.completion   = i2cms_pkg::COMP_READ;
                end
                default:
                begin
                    r.stop_request = 1'b1;
                    r.completion   = i2cms_pkg::COMP_WRITE;
                end
            endcase
        end
        r.read_data = m_data;
        return r;
    endfunction

    function automatic i2cms_pkg::req_t rand_item();
        i2cms_pkg::req_t t;
        t.operation        = 1'($urandom_range(0, 1));
        t.device_address   = 8'($urandom_range(0, 255));
        t.register_address = 8'($urandom_range(0, 255));
        t.write_value      = 8'($urandom_range(0, 255));
        t.read_request     = 1'($urandom_range(0, 1));
        t.byte_count       = 8'($urandom_range(0, 255));
        t.status_code      = 8'($urandom_range(0, 255));
        t.received_byte    = 8'($urandom_range(0, 255));
        return t;
    endfunction

    function automatic logic [7:0] rand_byte();
        return 8'($urandom_range(0, 255));
    endfunction

    task automatic send_item(input i2cms_pkg::req_t t);
        int gap;
        if (!calm && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 8);
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_valid <= 1'b1;
        req       <= t;
        @(posedge clk);
        while (!req_ready) @(posedge clk);
        pending_cmds.push_back(next_commands(t));
        sent++;
    endtask

    task automatic send_request(input logic rd, input logic [7:0] dev, input logic [7:0] ridx,
                                input logic [7:0] val, input logic [7:0] cnt);
        i2cms_pkg::req_t t;
        t                  = rand_item();
        t.operation        = i2cms_pkg::OP_REQUEST;
        t.read_request     = rd;
        t.device_address   = dev;
        t.register_address = ridx;
        t.write_value      = val;
        t.byte_count       = cnt;
        send_item(t);
    endtask

    task automatic send_event(input logic [7:0] code, input logic [7:0] rx);
        i2cms_pkg::req_t t;
        t               = rand_item();
        t.operation     = i2cms_pkg::OP_STATUS;
        t.status_code   = code;
        t.received_byte = rx;
        send_item(t);
    endtask

    task automatic wait_idle();
        req_valid <= 1'b0;
        @(posedge clk);
        while (pending_cmds.size() != 0) @(posedge clk);
    endtask

    task automatic cmp_field(input string name, input logic [7:0] want, input logic [7:0] got);
        if (want !== got)
        begin
            $error("%s: expected %0h, actual %0h", name, want, got);
            errors++;
        end
    endtask

    // response checker
    always @(posedge clk)
    begin
        i2cms_pkg::rsp_t want;
        if (rst_n && rsp_valid && rsp_ready)
        begin
            if (pending_cmds.size() == 0)
            begin
                $error("unexpected transaction on response channel");
                errors++;
            end
            else
            begin
                want = pending_cmds.pop_front();
                cmp_field("load_data", 8'(want.load_data), 8'(rsp.load_data));
                cmp_field("tx_byte", want.tx_byte, rsp.tx_byte);
                cmp_field("start_action", 8'(want.start_action), 8'(rsp.start_action));
                cmp_field("stop_request", 8'(want.stop_request), 8'(rsp.stop_request));
                cmp_field("ack_action", 8'(want.ack_action), 8'(rsp.ack_action));
                cmp_field("clear_interrupt", 8'(want.clear_interrupt),
                          8'(rsp.clear_interrupt));
                cmp_field("completion", 8'(want.completion), 8'(rsp.completion));
                cmp_field("read_data", want.read_data, rsp.read_data);
                checked++;
            end
        end
    end

    // receiver backpressure
    initial
    begin
        rsp_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (!calm && $urandom_range(0, 5) == 0)
            begin
                rsp_ready <= 1'b0;
                stall_len = $urandom_range(1, 8);
                repeat (stall_len) @(posedge clk);
            end
            rsp_ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > LIMIT)
        begin
            $display("tb_top: errors");
            $finish;
        end
    end

    // status events before any request: all-zero state
    task automatic test_reset_state();
        send_event(i2cms_pkg::ST_START, 8'h00);
        send_event(i2cms_pkg::ST_DATA_W_ACK, 8'hFF);
        send_event(i2cms_pkg::ST_ADDR_R_ACK, 8'h00);
        send_event(8'h00, 8'h00);
        send_event(8'hFF, 8'hFF);
        wait_idle();
    endtask

    task automatic test_write_transfer();
        send_request(1'b0, 8'hFF, 8'h00, 8'hFF, 8'd1);
        send_event(i2cms_pkg::ST_START, 8'h00);
        send_event(i2cms_pkg::ST_ADDR_W_ACK, 8'h00);
        send_event(i2cms_pkg::ST_DATA_W_ACK, 8'h00);
        send_event(i2cms_pkg::ST_DATA_W_ACK, 8'h00);
        wait_idle();
    endtask

    task automatic test_read_transfer();
        send_request(1'b0, 8'h00, 8'hFF, 8'h00, 8'd1);
        send_event(i2cms_pkg::ST_START, 8'h00);
        send_event(i2cms_pkg::ST_ADDR_W_ACK, 8'h00);
        send_request(1'b1, 8'hA5, 8'h5A, 8'h00, 8'd2);
        send_event(i2cms_pkg::ST_DATA_W_ACK, 8'h00);
        send_event(i2cms_pkg::ST_RESTART, 8'h00);
        send_event(i2cms_pkg::ST_ADDR_R_ACK, 8'h00);
        send_event(i2cms_pkg::ST_DATA_R_ACK, 8'hFF);
        send_event(i2cms_pkg::ST_DATA_R_ACK, 8'h00);
        send_event(i2cms_pkg::ST_DATA_R_NAK, 8'h5A);
        wait_idle();
    endtask

    task automatic test_byte_count_edges();
        send_request(1'b0, 8'h3C, 8'hC3, 8'h81, 8'd0);
        send_event(i2cms_pkg::ST_DATA_W_ACK, 8'h00);
        send_request(1'b1, 8'hC3, 8'h3C, 8'h7E, 8'd255);
        send_event(i2cms_pkg::ST_ADDR_R_ACK, 8'h00);
        send_event(i2cms_pkg::ST_DATA_R_ACK, 8'h99);
        wait_idle();
    endtask

    // tx counter runs from 0 through -256 and wraps to +255
    task automatic test_counter_wrap();
        send_request(1'b0, rand_byte(), rand_byte(), rand_byte(), 8'd0);
        repeat (260) send_event(i2cms_pkg::ST_DATA_W_ACK, rand_byte());
        wait_idle();
    endtask

    task automatic random_write_seq();
        int n;
        n = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 4) : 1;
        send_request(1'b0, rand_byte(), rand_byte(), rand_byte(), 8'(n));
        send_event(i2cms_pkg::ST_START, rand_byte());
        send_event(i2cms_pkg::ST_ADDR_W_ACK, rand_byte());
        repeat (n + 1) send_event(i2cms_pkg::ST_DATA_W_ACK, rand_byte());
    endtask

    task automatic random_read_seq();
        int n;
        n = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 5) : 1;
        send_request(1'b1, rand_byte(), rand_byte(), rand_byte(), 8'(n));
        send_event(i2cms_pkg::ST_START, rand_byte());
        send_event(i2cms_pkg::ST_ADDR_W_ACK, rand_byte());
        send_event(i2cms_pkg::ST_DATA_W_ACK, rand_byte());
        send_event(i2cms_pkg::ST_RESTART, rand_byte());
        send_event(i2cms_pkg::ST_ADDR_R_ACK, rand_byte());
        repeat ((n > 1) ? n - 1 : 0) send_event(i2cms_pkg::ST_DATA_R_ACK, rand_byte());
        send_event(i2cms_pkg::ST_DATA_R_NAK, rand_byte());
    endtask

    task automatic random_noise();
        logic [7:0] codes[7];
        int         k;
        codes = '{i2cms_pkg::ST_START, i2cms_pkg::ST_RESTART, i2cms_pkg::ST_ADDR_W_ACK,
                  i2cms_pkg::ST_DATA_W_ACK, i2cms_pkg::ST_ADDR_R_ACK,
                  i2cms_pkg::ST_DATA_R_ACK, i2cms_pkg::ST_DATA_R_NAK};
        repeat ($urandom_range(1, 4))
        begin
            k = $urandom_range(0, 9);
            if (k < 7)
                send_event(codes[k], rand_byte());
            else
                send_item(rand_item());
        end
    endtask

    task automatic test_random_transfers();
        int stop_at;
        int calm_at;
        int pick;
        stop_at = sent + 270;
        calm_at = stop_at - 60;
        while (sent < stop_at)
        begin
            if (sent >= calm_at)
                calm = 1'b1;
            pick = $urandom_range(0, 9);
            if (pick < 4)
                random_write_seq();
            else if (pick < 8)
                random_read_seq();
            else
                random_noise();
        end
    endtask

    initial
    begin
        rst_n     = 1'b0;
        req_valid = 1'b0;
        req       = '0;
        errors    = 0;
        sent      = 0;
        checked   = 0;
        cycles    = 0;
        calm      = 1'b0;
        m_dev     = '0;
        m_reg     = '0;
        m_data    = '0;
        m_tx      = '0;
        m_rx      = '0;
        m_rd      = 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_state();
        test_write_transfer();
        test_read_transfer();
        test_byte_count_edges();
        test_counter_wrap();
        test_random_transfers();

        wait_idle();
        repeat (8) @(posedge clk);
        $display("summary: %0d transactions driven, %0d results compared", sent, checked);
        $display("summary: write, read, restart, unknown-code and tx counter wrap paths run");
        if (errors == 0)
            $display("tb_top: clean");
        else
            $display("tb_top: errors");
        $finish;
    end

endmodule

FILE: filelist.f
hw/rtl/i2cms_pkg.sv
hw/rtl/i2cms_input_stage.sv
hw/rtl/i2cms_sequencer.sv
hw/rtl/i2cms_result_stage.sv
hw/rtl/i2c_master_register_sequencer.sv
tb/sv/tb_top.sv
